// File: rtl/smdx_pkg.sv
// Shared types, constants and routing helpers for the stereo downmix unit.
`default_nettype none

package smdx_pkg;

   localparam int SampleW   = 16;
   localparam int CountW    = 5;
   localparam int MaskW     = 18;
   localparam int PosW      = 5;
   localparam int ProdW     = 32;
   localparam int AccW      = 36;
   localparam int FracW     = 15;
   localparam int RoundW    = AccW - FracW;
   localparam int CsrDataW  = MaskW;
   localparam int CsrIndexW = 1;

   localparam int MaxChannels = 18;
   localparam int QueueDepth  = 4;
   localparam int LfeBit      = 3;

   localparam logic [CountW-1:0] CountReset = CountW'(2);
   localparam logic [MaskW-1:0]  MaskReset  = MaskW'(3);

   localparam logic [MaskW-1:0] LeftSideBits  = 18'h09250;
   localparam logic [MaskW-1:0] RightSideBits = 18'h244A0;

   localparam logic signed [SampleW-1:0] GainAtt   = 16'sd23170;
   localparam logic [AccW-1:0]           RoundHalf = AccW'(16384);

   localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;
   localparam logic signed [SampleW-1:0] SampleMax = 16'sh7FFF;

   localparam logic [CsrIndexW-1:0] RegChannelCount = 1'b0;
   localparam logic [CsrIndexW-1:0] RegSpeakerMask  = 1'b1;

   typedef enum logic [1:0] {
      GAIN_NONE,
      GAIN_UNITY,
      GAIN_ATT
   } gain_sel_type;

   typedef struct packed {
      gain_sel_type gain_l;
      gain_sel_type gain_r;
   } route_type;

   typedef struct packed {
      logic signed [SampleW-1:0] sample;
      gain_sel_type              gain_l;
      gain_sel_type              gain_r;
      logic                      last;
   } queue_entry_type;

   // Fixed routing of one speaker position bit to the two output sides.
   function automatic route_type speaker_route(input int bit_idx);
      route_type rt;
      rt.gain_l = GAIN_NONE;
      rt.gain_r = GAIN_NONE;
      if (bit_idx == 0) begin
         rt.gain_l = GAIN_UNITY;
      end else if (bit_idx == 1) begin
         rt.gain_r = GAIN_UNITY;
      end else if (LeftSideBits[bit_idx]) begin
         rt.gain_l = GAIN_ATT;
      end else if (RightSideBits[bit_idx]) begin
         rt.gain_r = GAIN_ATT;
      end else if (bit_idx != LfeBit) begin
         rt.gain_l = GAIN_ATT;
         rt.gain_r = GAIN_ATT;
      end
      return rt;
   endfunction

   // Number of set mask bits strictly below position upto.
   function automatic logic [PosW-1:0] popcount_below(input logic [MaskW-1:0] mask,
                                                      input int upto);
      logic [PosW-1:0] cnt;
      cnt = '0;
      for (int j = 0; j < MaskW; j++) begin
         if (j < upto) begin
            cnt = cnt + PosW'(mask[j]);
         end
      end
      return cnt;
   endfunction

endpackage

`default_nettype wire

// File: rtl/smdx_front.sv
// Front end: configuration registers, channel tracking and routing of each request.
`default_nettype none

module smdx_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_we,
   input  wire [smdx_pkg::CsrIndexW-1:0]    csr_index,
   input  wire [smdx_pkg::CsrDataW-1:0]     csr_wdata,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire signed [smdx_pkg::SampleW-1:0] req_sample,
   output logic                             push_valid,
   input  wire                              push_ready,
   output smdx_pkg::queue_entry_type        push_data
);
   import smdx_pkg::*;

   logic [CountW-1:0] channel_count_ff;
   logic [CountW-1:0] channel_count_in;
   logic [MaskW-1:0]  speaker_mask_ff;
   logic [MaskW-1:0]  speaker_mask_in;
   logic [PosW-1:0]   prefix_ff [MaskW];
   logic [PosW-1:0]   prefix_in [MaskW];
   logic [PosW-1:0]   pos_ff;
   logic [PosW-1:0]   pos_in;
   logic [CountW-1:0] eff_count;
   logic [PosW:0]     pos_plus_one;
   logic              last;
   logic              accept;
   route_type         rt;

   always_comb begin
      channel_count_in = channel_count_ff;
      speaker_mask_in  = speaker_mask_ff;
      if (csr_we) begin
         case (csr_index)
            RegChannelCount: channel_count_in = csr_wdata[CountW-1:0];
            RegSpeakerMask:  speaker_mask_in  = csr_wdata[MaskW-1:0];
            default: ;
         endcase
      end
   end

   // The rank of every mask bit is kept precomputed, so a request only needs
   // one compare per bit to find its speaker position.
   always_comb begin
      for (int b = 0; b < MaskW; b++) begin
         prefix_in[b] = popcount_below(speaker_mask_in, b);
      end
   end

   always_comb begin
      if (channel_count_ff == '0) begin
         eff_count = CountW'(1);
      end else if (channel_count_ff > CountW'(MaxChannels)) begin
         eff_count = CountW'(MaxChannels);
      end else begin
         eff_count = channel_count_ff;
      end
      pos_plus_one = {1'b0, pos_ff} + (PosW+1)'(1);
      last         = pos_plus_one >= {1'b0, eff_count};
   end

   always_comb begin
      rt.gain_l = GAIN_NONE;
      rt.gain_r = GAIN_NONE;
      if (speaker_mask_ff == '0) begin
         if (pos_ff[0]) begin
            rt.gain_r = GAIN_ATT;
         end else begin
            rt.gain_l = GAIN_ATT;
         end
      end else begin
         for (int b = 0; b < MaskW; b++) begin
            if (speaker_mask_ff[b] && (prefix_ff[b] == pos_ff)) begin
               rt = speaker_route(b);
            end
         end
      end
   end

   assign req_ready        = push_ready;
   assign push_valid       = req_valid;
   assign accept           = req_valid && push_ready;
   assign push_data.sample = req_sample;
   assign push_data.gain_l = rt.gain_l;
   assign push_data.gain_r = rt.gain_r;
   assign push_data.last   = last;

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         pos_in = last ? '0 : pos_plus_one[PosW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= CountReset;
         speaker_mask_ff  <= MaskReset;
         pos_ff           <= '0;
         for (int b = 0; b < MaskW; b++) begin
            prefix_ff[b] <= popcount_below(MaskReset, b);
         end
      end else begin
         channel_count_ff <= channel_count_in;
         speaker_mask_ff  <= speaker_mask_in;
         pos_ff           <= pos_in;
         for (int b = 0; b < MaskW; b++) begin
            prefix_ff[b] <= prefix_in[b];
         end
      end
   end

`ifndef SYNTHESIS
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      accept && last |=> pos_ff == '0)
      else $error("channel position not cleared after the last request of a frame");
`endif

endmodule

`default_nettype wire

// File: rtl/smdx_queue.sv
// Short request queue between the front end and the arithmetic back end.
`default_nettype none

module smdx_queue #(
   parameter int DEPTH = smdx_pkg::QueueDepth
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push_valid,
   output logic                       push_ready,
   input  smdx_pkg::queue_entry_type  push_data,
   output logic                       pop_valid,
   input  wire                        pop_ready,
   output smdx_pkg::queue_entry_type  pop_data
);
   import smdx_pkg::*;

   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW  = $clog2(DEPTH + 1);

   queue_entry_type entries_ff [DEPTH];
   logic [AddrW-1:0] wr_ptr_ff;
   logic [AddrW-1:0] wr_ptr_in;
   logic [AddrW-1:0] rd_ptr_ff;
   logic [AddrW-1:0] rd_ptr_in;
   logic [CntW-1:0]  count_ff;
   logic [CntW-1:0]  count_in;
   logic             push;
   logic             pop;

   assign push_ready = count_ff != CntW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AddrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AddrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AddrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AddrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CntW'(1))
      else $error("queue fill count did not follow a lone push");
`endif

endmodule

`default_nettype wire

// File: rtl/smdx_back.sv
// Back end: gain multiply, frame accumulation, rounding and saturation to the output register.
`default_nettype none

module smdx_back (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 pop_valid,
   output logic                                pop_ready,
   input  smdx_pkg::queue_entry_type           pop_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic signed [smdx_pkg::SampleW-1:0] rsp_left_sample,
   output logic signed [smdx_pkg::SampleW-1:0] rsp_right_sample
);
   import smdx_pkg::*;

   logic                      adv;
   logic signed [ProdW-1:0]   att_prod;
   logic signed [ProdW-1:0]   unity_prod;
   logic signed [ProdW-1:0]   prod_l_in;
   logic signed [ProdW-1:0]   prod_r_in;

   logic                      s1_valid_ff;
   logic                      s1_last_ff;
   logic signed [ProdW-1:0]   prod_l_ff;
   logic signed [ProdW-1:0]   prod_r_ff;

   logic signed [AccW-1:0]    sum_l;
   logic signed [AccW-1:0]    sum_r;
   logic signed [AccW-1:0]    acc_l_ff;
   logic signed [AccW-1:0]    acc_r_ff;
   logic                      fin_valid_ff;
   logic signed [AccW-1:0]    fin_l_ff;
   logic signed [AccW-1:0]    fin_r_ff;

   logic                      mag_valid_ff;
   logic                      neg_l_ff;
   logic                      neg_r_ff;
   logic [AccW-1:0]           mag_l_ff;
   logic [AccW-1:0]           mag_r_ff;

   logic [AccW-1:0]           rnd_l;
   logic [AccW-1:0]           rnd_r;
   logic                      rsp_valid_ff;
   logic signed [SampleW-1:0] rsp_left_ff;
   logic signed [SampleW-1:0] rsp_right_ff;

   function automatic logic signed [SampleW-1:0] saturate(input logic neg,
                                                          input logic [RoundW-1:0] mag);
      logic signed [SampleW-1:0] res;
      if (neg) begin
         if (mag > RoundW'(32768)) begin
            res = SampleMin;
         end else begin
            res = -signed'(mag[SampleW-1:0]);
         end
      end else begin
         if (mag > RoundW'(32767)) begin
            res = SampleMax;
         end else begin
            res = signed'(mag[SampleW-1:0]);
         end
      end
      return res;
   endfunction

   // The whole back pipeline moves together and holds when the result waits.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign pop_ready = adv;

   assign att_prod   = ProdW'(pop_data.sample) * ProdW'(GainAtt);
   assign unity_prod = ProdW'(pop_data.sample) <<< FracW;

   always_comb begin
      case (pop_data.gain_l)
         GAIN_UNITY: prod_l_in = unity_prod;
         GAIN_ATT:   prod_l_in = att_prod;
         default:    prod_l_in = '0;
      endcase
      case (pop_data.gain_r)
         GAIN_UNITY: prod_r_in = unity_prod;
         GAIN_ATT:   prod_r_in = att_prod;
         default:    prod_r_in = '0;
      endcase
   end

   assign sum_l = acc_l_ff + AccW'(prod_l_ff);
   assign sum_r = acc_r_ff + AccW'(prod_r_ff);
   assign rnd_l = mag_l_ff + RoundHalf;
   assign rnd_r = mag_r_ff + RoundHalf;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         mag_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_l_ff     <= '0;
         acc_r_ff     <= '0;
      end else if (adv) begin
         s1_valid_ff  <= pop_valid;
         fin_valid_ff <= s1_valid_ff && s1_last_ff;
         mag_valid_ff <= fin_valid_ff;
         rsp_valid_ff <= mag_valid_ff;
         if (s1_valid_ff) begin
            if (s1_last_ff) begin
               acc_l_ff <= '0;
               acc_r_ff <= '0;
            end else begin
               acc_l_ff <= sum_l;
               acc_r_ff <= sum_r;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_last_ff   <= pop_data.last;
         prod_l_ff    <= prod_l_in;
         prod_r_ff    <= prod_r_in;
         fin_l_ff     <= sum_l;
         fin_r_ff     <= sum_r;
         neg_l_ff     <= fin_l_ff[AccW-1];
         neg_r_ff     <= fin_r_ff[AccW-1];
         mag_l_ff     <= fin_l_ff[AccW-1] ? AccW'(-fin_l_ff) : AccW'(fin_l_ff);
         mag_r_ff     <= fin_r_ff[AccW-1] ? AccW'(-fin_r_ff) : AccW'(fin_r_ff);
         rsp_left_ff  <= saturate(neg_l_ff, rnd_l[AccW-1:FracW]);
         rsp_right_ff <= saturate(neg_r_ff, rnd_r[AccW-1:FracW]);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_sample  = rsp_left_ff;
   assign rsp_right_sample = rsp_right_ff;

`ifndef SYNTHESIS
   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      adv && s1_valid_ff && s1_last_ff |=> acc_l_ff == '0 && acc_r_ff == '0)
      else $error("accumulators not cleared at the end of a frame");

   a_stall_holds_acc: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(acc_l_ff) && $stable(acc_r_ff))
      else $error("accumulators changed while the back end was stalled");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(mag_valid_ff))
      else $error("result raised without a finished frame behind it");
`endif

endmodule

`default_nettype wire

// File: rtl/multichannel_stereo_downmix_unit.sv
// Top level of the surround-to-stereo downmix unit.
//
//  Channel  Direction  Handshake              Payload
//  req      in         req_valid/req_ready    req_sample (signed 16)
//  rsp      out        rsp_valid/rsp_ready    rsp_left_sample, rsp_right_sample (signed 16)
//  csr      in         csr_we (no wait)       csr_index, csr_wdata (18)
//
// One request is taken per cycle while the result side keeps up.
// A frame's last request goes from the queue output into the product register,
// then through the accumulate, magnitude and round/saturate stages to the result.
// A stalled result freezes the back pipeline; the queue then fills and
// req_ready drops once it holds QUEUE_DEPTH requests.
// Reset is synchronous and restores two channels with a front left/right mask.
`default_nettype none

module multichannel_stereo_downmix_unit #(
   parameter int QUEUE_DEPTH = smdx_pkg::QueueDepth
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_we,
   input  wire [smdx_pkg::CsrIndexW-1:0]       csr_index,
   input  wire [smdx_pkg::CsrDataW-1:0]        csr_wdata,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire signed [smdx_pkg::SampleW-1:0]  req_sample,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic signed [smdx_pkg::SampleW-1:0] rsp_left_sample,
   output logic signed [smdx_pkg::SampleW-1:0] rsp_right_sample
);
   import smdx_pkg::*;

   logic            push_valid;
   logic            push_ready;
   queue_entry_type push_data;
   logic            pop_valid;
   logic            pop_ready;
   queue_entry_type pop_data;

   smdx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   smdx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   smdx_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_data         (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_left_sample  (rsp_left_sample),
      .rsp_right_sample (rsp_right_sample)
   );

endmodule

`default_nettype wire

// File: bench/tb_multichannel_stereo_downmix_unit.sv
// Self-checking testbench for the surround-to-stereo downmix unit.
`timescale 1ns / 100ps

module tb_multichannel_stereo_downmix_unit;
   import smdx_pkg::*;

   localparam longint GainUnityQ15  = 32768;
   localparam int     DrainCycles   = 12;
   localparam int     HoldOffCycles = 300;
   localparam int     RandomItems   = 1900;
   localparam int     CycleLimit    = 600000;

   typedef struct packed {
      logic signed [SampleW-1:0] left;
      logic signed [SampleW-1:0] right;
   } stereo_result_type;

   typedef enum logic [1:0] {
      RX_STEADY,
      RX_COIN,
      RX_SPARSE
   } rx_pattern_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_we = 1'b0;
   logic [CsrIndexW-1:0]      csr_index = '0;
   logic [CsrDataW-1:0]       csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [SampleW-1:0] req_sample = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [SampleW-1:0] rsp_left_sample;
   logic signed [SampleW-1:0] rsp_right_sample;

   // Predictor state and its copy of the configuration registers.
   logic [CountW-1:0] cfg_count = CountReset;
   logic [MaskW-1:0]  cfg_mask  = MaskReset;
   logic [PosW-1:0]   mix_pos   = '0;
   longint            left_sum  = 0;
   longint            right_sum = 0;

   stereo_result_type pending_stereo[$];
   int                mismatch_count = 0;
   int                cycle_count = 0;

   int burst_left = 0;
   int gap_max = 0;

   int             hold_off_requests = 0;
   int             hold_off_served = 0;
   int             hold_left = 0;
   rx_pattern_type rx_pattern = RX_STEADY;
   int             rx_pattern_left = 0;

   multichannel_stereo_downmix_unit uut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_left_sample  (rsp_left_sample),
      .rsp_right_sample (rsp_right_sample)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("** multichannel_stereo_downmix_unit: FAILED **");
         $finish;
      end
   end

   function automatic int frame_length(input logic [CountW-1:0] count);
      if (count == '0) begin
         return 1;
      end else if (int'(count) > MaxChannels) begin
         return MaxChannels;
      end
      return int'(count);
   endfunction

   // Channel k takes the route of the k-th set mask bit; an empty mask pairs channels.
   function automatic route_type channel_gains(input logic [MaskW-1:0] mask,
                                               input logic [PosW-1:0] pos);
      route_type g;
      int        seen;
      int        b;
      g.gain_l = GAIN_NONE;
      g.gain_r = GAIN_NONE;
      seen = 0;
      if (mask == '0) begin
         if (pos[0]) begin
            g.gain_r = GAIN_ATT;
         end else begin
            g.gain_l = GAIN_ATT;
         end
      end else begin
         for (b = 0; b < MaskW; b++) begin
            if (mask[b]) begin
               if (seen == int'(pos)) begin
                  if (b == 0) begin
                     g.gain_l = GAIN_UNITY;
                  end else if (b == 1) begin
                     g.gain_r = GAIN_UNITY;
                  end else if (LeftSideBits[b]) begin
                     g.gain_l = GAIN_ATT;
                  end else if (RightSideBits[b]) begin
                     g.gain_r = GAIN_ATT;
                  end else if (b != LfeBit) begin
                     g.gain_l = GAIN_ATT;
                     g.gain_r = GAIN_ATT;
                  end
               end
               seen++;
            end
         end
      end
      return g;
   endfunction

   function automatic longint gain_q15(input gain_sel_type g);
      case (g)
         GAIN_UNITY: return GainUnityQ15;
         GAIN_ATT:   return longint'(GainAtt);
         default:    return 0;
      endcase
   endfunction

   function automatic logic signed [SampleW-1:0] round_saturate(input longint acc);
      longint mag;
      mag = (acc < 0) ? -acc : acc;
      mag = (mag + 16384) >> FracW;
      if (acc < 0) begin
         return (mag > 32768) ? SampleMin : SampleW'(-mag);
      end
      return (mag > 32767) ? SampleMax : SampleW'(mag);
   endfunction

   task automatic mix_sample(input logic signed [SampleW-1:0] value);
      route_type         g;
      stereo_result_type mixed;
      g = channel_gains(cfg_mask, mix_pos);
      left_sum  += longint'(value) * gain_q15(g.gain_l);
      right_sum += longint'(value) * gain_q15(g.gain_r);
      if (int'(mix_pos) + 1 >= frame_length(cfg_count)) begin
         mixed.left  = round_saturate(left_sum);
         mixed.right = round_saturate(right_sum);
         pending_stereo.insert(pending_stereo.size(), mixed);
         mix_pos   = '0;
         left_sum  = 0;
         right_sum = 0;
      end else begin
         mix_pos = mix_pos + 1'b1;
      end
   endtask

   function automatic logic signed [SampleW-1:0] pick_sample();
      case ($urandom_range(0, 15))
         0:       return SampleMin;
         1:       return SampleMax;
         2:       return 16'sd8192;
         3:       return -16'sd8192;
         4:       return '0;
         5:       return -16'sd1;
         default: return SampleW'($urandom);
      endcase
   endfunction

   // Requests go out in bursts; a new burst may open with a gap of idle cycles.
   task automatic send_sample(input logic signed [SampleW-1:0] value);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (gap_max > 0) begin
            gap = $urandom_range(0, gap_max);
         end
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      mix_sample(value);
   endtask

   task automatic write_reg(input logic [CsrIndexW-1:0] idx, input logic [CsrDataW-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == RegChannelCount) begin
         cfg_count = data[CountW-1:0];
      end else begin
         cfg_mask = data;
      end
      @(posedge clock);
   endtask

   // Partial frames leave no result, so the pipe is given time to empty once the
   // last expected result is out; only cycles with the receiver ready count.
   task automatic wait_drained();
      int settled;
      settled = 0;
      req_valid <= 1'b0;
      while (pending_stereo.size() != 0 || settled < DrainCycles) begin
         @(posedge clock);
         if (pending_stereo.size() != 0) begin
            settled = 0;
         end else if (rsp_ready) begin
            settled++;
         end
      end
   endtask

   task automatic test_reset_defaults();
      gap_max = 0;
      send_sample(SampleMax);
      send_sample(SampleMin);
      send_sample(SampleMin);
      send_sample(SampleMax);
      wait_drained();
   endtask

   task automatic test_rounding_tie();
      write_reg(RegChannelCount, 2);
      write_reg(RegSpeakerMask, '0);
      gap_max = 3;
      send_sample(16'sd8192);
      send_sample(-16'sd8192);
      send_sample(16'sd1);
      send_sample(-16'sd1);
      wait_drained();
   endtask

   task automatic test_saturation();
      write_reg(RegSpeakerMask, 18'h00005);
      send_sample(SampleMax);
      send_sample(SampleMax);
      send_sample(SampleMin);
      send_sample(SampleMin);
      wait_drained();
   endtask

   task automatic test_zero_count();
      // The upper data bits are set as well; only the low five reach the count.
      write_reg(RegChannelCount, 18'h3FFE0);
      write_reg(RegSpeakerMask, 18'h00008);
      send_sample(16'sd12345);
      wait_drained();
      write_reg(RegSpeakerMask, 18'h00001);
      send_sample(SampleMin);
      send_sample(SampleMax);
      wait_drained();
   endtask

   task automatic test_count_above_max();
      int i;
      write_reg(RegChannelCount, 31);
      write_reg(RegSpeakerMask, 18'h3FFFF);
      gap_max = 2;
      for (i = 0; i < MaxChannels; i++) begin
         send_sample(i[0] ? SampleMin : SampleMax);
      end
      wait_drained();
   endtask

   task automatic test_unmapped_channel();
      write_reg(RegChannelCount, 3);
      write_reg(RegSpeakerMask, 18'h00002);
      send_sample(16'sd20000);
      send_sample(-16'sd30000);
      send_sample(16'sd777);
      wait_drained();
   endtask

   task automatic test_midframe_update();
      write_reg(RegChannelCount, 4);
      write_reg(RegSpeakerMask, '0);
      send_sample(16'sd1000);
      send_sample(-16'sd2000);
      send_sample(16'sd3000);
      wait_drained();
      // The open frame is kept and closes on the next request under the new count.
      write_reg(RegChannelCount, 2);
      send_sample(16'sd4000);
      wait_drained();
      write_reg(RegChannelCount, 3);
      write_reg(RegSpeakerMask, 18'h00007);
      send_sample(16'sd5000);
      wait_drained();
      write_reg(RegSpeakerMask, 18'h00030);
      send_sample(16'sd6000);
      send_sample(-16'sd7000);
      wait_drained();
   endtask

   task automatic test_backpressure();
      int i;
      write_reg(RegChannelCount, 1);
      write_reg(RegSpeakerMask, 18'h00001);
      gap_max = 0;
      burst_left = 0;
      hold_off_requests++;
      for (i = 0; i < 40; i++) begin
         send_sample(pick_sample());
      end
      wait_drained();
   endtask

   task automatic test_random_mix();
      int                sent;
      int                total;
      int                n;
      logic [CountW-1:0] count_pick;
      logic [MaskW-1:0]  mask_pick;
      logic [CsrDataW-1:0] count_data;
      int                skip;
      int                i;
      sent = 0;
      while (sent < RandomItems) begin
         case ($urandom_range(0, 11))
            0:       count_pick = '0;
            1:       count_pick = CountW'($urandom_range(19, 31));
            2:       count_pick = CountW'(MaxChannels);
            3:       count_pick = CountW'($urandom_range(9, 17));
            default: count_pick = CountW'($urandom_range(1, 8));
         endcase
         case ($urandom_range(0, 9))
            0:       mask_pick = '0;
            1:       mask_pick = 18'h3FFFF;
            2:       mask_pick = 18'h0003F;
            3:       mask_pick = 18'h0063F;
            4:       mask_pick = MaskW'($urandom & $urandom & $urandom);
            5:       mask_pick = 18'h00003;
            default: mask_pick = MaskW'($urandom);
         endcase
         count_data = CsrDataW'($urandom);
         count_data[CountW-1:0] = count_pick;
         skip = $urandom_range(0, 5);
         if ($urandom_range(0, 1)) begin
            if (skip != 1) write_reg(RegChannelCount, count_data);
            if (skip != 2) write_reg(RegSpeakerMask, mask_pick);
         end else begin
            if (skip != 2) write_reg(RegSpeakerMask, mask_pick);
            if (skip != 1) write_reg(RegChannelCount, count_data);
         end
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         n = frame_length(cfg_count);
         total = n * $urandom_range(1, 10);
         // Now and then a phase stops inside a frame, so the next write lands mid-frame.
         if (n > 1 && $urandom_range(0, 3) == 0) begin
            total += $urandom_range(1, n - 1);
         end
         for (i = 0; i < total; i++) begin
            send_sample(pick_sample());
         end
         sent += total;
         wait_drained();
      end
   endtask

   // The receiver stalls on randomly chosen patterns that change from time to time, and
   // holds off completely for a long stretch when the test asks for it.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_off_served != hold_off_requests) begin
         hold_off_served <= hold_off_requests;
         hold_left       <= HoldOffCycles;
         rsp_ready       <= 1'b0;
      end else begin
         if (rx_pattern_left == 0) begin
            case ($urandom_range(0, 3))
               0:       rx_pattern <= RX_SPARSE;
               1:       rx_pattern <= RX_COIN;
               default: rx_pattern <= RX_STEADY;
            endcase
            rx_pattern_left <= $urandom_range(20, 200);
         end else begin
            rx_pattern_left <= rx_pattern_left - 1;
         end
         case (rx_pattern)
            RX_COIN:   rsp_ready <= $urandom_range(0, 1);
            RX_SPARSE: rsp_ready <= ($urandom_range(0, 7) == 0);
            default:   rsp_ready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      stereo_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_stereo.size() == 0) begin
            $display("%0t: unexpected result, expected none, got left %0d right %0d",
                     $time, rsp_left_sample, rsp_right_sample);
            mismatch_count++;
         end else begin
            want = pending_stereo.pop_front();
            if (rsp_left_sample !== want.left) begin
               $display("%0t: left_sample expected %0d, got %0d",
                        $time, want.left, rsp_left_sample);
               mismatch_count++;
            end
            if (rsp_right_sample !== want.right) begin
               $display("%0t: right_sample expected %0d, got %0d",
                        $time, want.right, rsp_right_sample);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_rounding_tie();
      test_saturation();
      test_zero_count();
      test_count_above_max();
      test_unmapped_channel();
      test_midframe_update();
      test_backpressure();
      test_random_mix();
      wait_drained();
      if (mismatch_count == 0 && pending_stereo.size() == 0) begin
         $display("** multichannel_stereo_downmix_unit: PASSED **");
      end else begin
         $display("** multichannel_stereo_downmix_unit: FAILED **");
      end
      $finish;
   end

endmodule
